@@ hdl/rrwl_pkg.sv @@
// ----------------------------------------------------------------------------
// rrwl_pkg
// Shared types and codes for the reentrant reader-writer lock unit.
// ----------------------------------------------------------------------------
package rrwl_pkg;

   localparam int READER_SLOTS_DEF = 16;
   localparam int ID_BITS_DEF      = 8;
   localparam int STATUS_BITS      = 3;
   localparam int OP_BITS          = 2;
   localparam int REENTRY_BITS     = 16;

   localparam logic [REENTRY_BITS-1:0] REENTRY_MAX = {REENTRY_BITS{1'b1}};

   // request operations
   localparam logic [OP_BITS-1:0] OP_ACQ_SHARED = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REL_SHARED = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ACQ_EXCL   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_REL_EXCL   = 2'd3;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_HELD_OTHER = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_READERS    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DEADLOCK   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_MISUSE     = 3'd5;

   // reader list engine commands
   localparam logic [1:0] ENG_APPEND = 2'd0;  // write id at the list tail
   localparam logic [1:0] ENG_REMOVE = 2'd1;  // find first match, shift down
   localparam logic [1:0] ENG_SURVEY = 2'd2;  // full scan: any match, all match

   typedef struct packed {
      logic       start;
      logic [1:0] kind;
   } rrwl_eng_cmd_type;

   typedef struct packed {
      logic done;   // one-cycle pulse at the end of a remove or survey
      logic found;  // some entry matched the id
      logic only;   // every entry matched the id
   } rrwl_eng_stat_type;

endpackage

@@ hdl/rrwl_if.sv @@
// ----------------------------------------------------------------------------
// rrwl_req_if / rrwl_rsp_if
// Valid/ready channels for lock requests and lock responses.
// ----------------------------------------------------------------------------
interface rrwl_req_if #(
   parameter int ID_BITS = rrwl_pkg::ID_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic [rrwl_pkg::OP_BITS-1:0] operation;
   logic [ID_BITS-1:0]          requester_id;

   modport source (output valid, output operation, output requester_id, input ready);
   modport sink   (input valid, input operation, input requester_id, output ready);
endinterface

interface rrwl_rsp_if #(
   parameter int READER_SLOTS = rrwl_pkg::READER_SLOTS_DEF,
   parameter int ID_BITS      = rrwl_pkg::ID_BITS_DEF
) ();
   localparam int CNT_BITS = $clog2(READER_SLOTS + 1);

   logic                             valid;
   logic                             ready;
   logic [rrwl_pkg::STATUS_BITS-1:0] status;
   logic [CNT_BITS-1:0]              reader_total;
   logic [ID_BITS-1:0]               owner_now;

   modport source (output valid, output status, output reader_total, output owner_now,
                   input ready);
   modport sink   (input valid, input status, input reader_total, input owner_now,
                   output ready);
endinterface

@@ hdl/rrwl_scan.sv @@
// ----------------------------------------------------------------------------
// rrwl_scan
// Reader list memory with one compare/shift engine stepping one slot a cycle.
// ----------------------------------------------------------------------------
module rrwl_scan #(
   parameter int READER_SLOTS = rrwl_pkg::READER_SLOTS_DEF,
   parameter int ID_BITS      = rrwl_pkg::ID_BITS_DEF,
   localparam int CNT_BITS    = $clog2(READER_SLOTS + 1),
   localparam int IDX_BITS    = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rrwl_pkg::rrwl_eng_cmd_type  cmd,
   input  logic [ID_BITS-1:0]          id,
   input  logic [CNT_BITS-1:0]         count,
   output rrwl_pkg::rrwl_eng_stat_type stat
);
   import rrwl_pkg::*;

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SCAN  = 2'd1;
   localparam logic [1:0] E_SHIFT = 2'd2;

   logic [ID_BITS-1:0]  mem [0:READER_SLOTS-1];
   logic [ID_BITS-1:0]  rd_data_ff;

   logic [1:0]          estate_ff, estate_in;
   logic                remove_ff, remove_in;
   logic [CNT_BITS-1:0] issue_ff, issue_in;     // next slot to read
   logic                stg_vld_ff, stg_vld_in; // read data valid this cycle
   logic [CNT_BITS-1:0] stg_idx_ff, stg_idx_in; // slot of rd_data_ff
   logic                has_ff, has_in;
   logic                only_ff, only_in;
   logic                done_ff, done_in;

   logic [IDX_BITS-1:0] rd_addr;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   logic [ID_BITS-1:0]  wr_data;
   logic                issue_go;
   logic                match;
   logic [CNT_BITS-1:0] stg_prev;

   assign issue_go = (issue_ff < count);
   assign match    = stg_vld_ff && (rd_data_ff == id);
   assign stg_prev = stg_idx_ff - CNT_BITS'(1);
   assign rd_addr  = issue_ff[IDX_BITS-1:0];

   always_comb begin
      estate_in  = estate_ff;
      remove_in  = remove_ff;
      issue_in   = issue_ff;
      stg_vld_in = 1'b0;
      stg_idx_in = issue_ff;
      has_in     = has_ff;
      only_in    = only_ff;
      done_in    = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count[IDX_BITS-1:0];
      wr_data    = id;

      unique case (estate_ff)
         E_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.kind) inside
                  ENG_APPEND: begin
                     wr_en = 1'b1;
                  end
                  ENG_REMOVE, ENG_SURVEY: begin
                     remove_in = (cmd.kind == ENG_REMOVE);
                     issue_in  = '0;
                     has_in    = 1'b0;
                     only_in   = 1'b1;
                     estate_in = E_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         E_SCAN: begin
            stg_vld_in = issue_go;
            issue_in   = issue_ff + CNT_BITS'(issue_go);
            if (stg_vld_ff) begin
               has_in  = has_ff | match;
               only_in = only_ff & match;
            end
            if (remove_ff && match) begin
               // first hit: close the gap starting at the slot after it
               issue_in   = stg_idx_ff + CNT_BITS'(1);
               stg_vld_in = 1'b0;
               estate_in  = E_SHIFT;
            end else if (!issue_go && !stg_vld_ff) begin
               done_in   = 1'b1;
               estate_in = E_IDLE;
            end
         end
         E_SHIFT: begin
            stg_vld_in = issue_go;
            issue_in   = issue_ff + CNT_BITS'(issue_go);
            wr_en      = stg_vld_ff;
            wr_addr    = stg_prev[IDX_BITS-1:0];
            wr_data    = rd_data_ff;
            if (!issue_go && !stg_vld_ff) begin
               done_in   = 1'b1;
               estate_in = E_IDLE;
            end
         end
         default: begin
            estate_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         estate_ff  <= E_IDLE;
         stg_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         estate_ff  <= estate_in;
         stg_vld_ff <= stg_vld_in;
         done_ff    <= done_in;
      end
      remove_ff  <= remove_in;
      issue_ff   <= issue_in;
      stg_idx_ff <= stg_idx_in;
      has_ff     <= has_in;
      only_ff    <= only_in;
   end

   assign stat.done  = done_ff;
   assign stat.found = has_ff;
   assign stat.only  = only_ff;

endmodule

@@ hdl/reentrant_reader_writer_lock_unit.sv @@
// ----------------------------------------------------------------------------
// reentrant_reader_writer_lock_unit
// Reentrant reader-writer lock: shared reader list plus exclusive owner.
// ----------------------------------------------------------------------------
// Usage:
//   req  (valid/ready): one lock request per transaction, an operation
//        (acquire/release, shared/exclusive) and a nonzero requester id.
//   rsp  (valid/ready): exactly one response transaction per request with
//        status, reader entries after the request and the exclusive owner.
// Operation:
//   Requests that need no list walk (shared acquire, exclusive release,
//   re-entry, rejects) are answered straight from the decide step. Shared
//   release and exclusive acquire with readers present walk the reader list
//   one slot a cycle through the single compare/shift engine; a release
//   that finds its id also shifts the later entries down (the shift picks
//   up right after the first match). One request is processed at a time;
//   req.ready is high only while the sequencer is idle, so a new request
//   is taken only after the previous one has been placed in the response
//   register.
// Reset:
//   Synchronous, active high. Reader count, owner and reentry count clear;
//   list contents are not cleared, only entries below the count are read.
// Backpressure:
//   The response sits in an output register. A new request can be taken
//   while it waits; that request's answer holds until rsp.ready drains it.
// ----------------------------------------------------------------------------
module reentrant_reader_writer_lock_unit #(
   parameter int READER_SLOTS = rrwl_pkg::READER_SLOTS_DEF,
   parameter int ID_BITS      = rrwl_pkg::ID_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rrwl_req_if.sink   req,
   rrwl_rsp_if.source rsp
);
   import rrwl_pkg::*;

   localparam int CNT_BITS = $clog2(READER_SLOTS + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [OP_BITS-1:0]      op_ff, op_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;

   // lock state
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [ID_BITS-1:0]      owner_ff, owner_in;
   logic [REENTRY_BITS-1:0] reentry_ff, reentry_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [CNT_BITS-1:0]     rsp_total_ff, rsp_total_in;
   logic [ID_BITS-1:0]      rsp_owner_ff, rsp_owner_in;

   rrwl_eng_cmd_type        eng_cmd;
   rrwl_eng_stat_type       eng_stat;

   logic                    req_take;
   logic                    owner_foreign;
   logic                    reentry_full;
   logic                    rsp_free;

   assign req.ready     = (state_ff == S_IDLE);
   assign req_take      = req.valid && req.ready;
   // someone other than this requester holds the exclusive lock
   assign owner_foreign = (owner_ff != '0) && (owner_ff != id_ff);
   assign reentry_full  = (reentry_ff == REENTRY_MAX);
   assign rsp_free      = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      owner_in      = owner_ff;
      reentry_in    = reentry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_owner_in  = rsp_owner_ff;
      eng_cmd.start = 1'b0;
      eng_cmd.kind  = ENG_SURVEY;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req.operation;
               id_in    = req.requester_id;
               state_in = S_DECIDE;
            end
         end

         // All checks that need no list walk; list work goes to the engine.
         S_DECIDE: begin
            state_in  = S_FINISH;
            status_in = ST_OK;
            if (id_ff == '0) begin
               status_in = ST_MISUSE;      // reserved id
            end else begin
               unique case (op_ff)
                  OP_ACQ_SHARED: begin
                     if (owner_foreign) begin
                        status_in = ST_HELD_OTHER;
                     end else if (count_ff >= CNT_BITS'(READER_SLOTS)) begin
                        status_in = ST_FULL;
                     end else begin
                        eng_cmd.start = 1'b1;
                        eng_cmd.kind  = ENG_APPEND;
                        count_in      = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_REL_SHARED: begin
                     if (owner_foreign || (count_ff == '0)) begin
                        status_in = ST_MISUSE;
                     end else begin
                        eng_cmd.start = 1'b1;
                        eng_cmd.kind  = ENG_REMOVE;
                        state_in      = S_WAIT;
                     end
                  end
                  OP_ACQ_EXCL: begin
                     if (owner_ff == id_ff) begin
                        // re-entry by the current owner
                        if (reentry_full) begin
                           status_in = ST_MISUSE;
                        end else begin
                           reentry_in = reentry_ff + REENTRY_BITS'(1);
                        end
                     end else if (owner_ff != '0) begin
                        status_in = ST_HELD_OTHER;
                     end else if (count_ff != '0) begin
                        // readers present: need to know whose they are
                        eng_cmd.start = 1'b1;
                        eng_cmd.kind  = ENG_SURVEY;
                        state_in      = S_WAIT;
                     end else if (reentry_full) begin
                        status_in = ST_MISUSE;
                     end else begin
                        owner_in   = id_ff;
                        reentry_in = reentry_ff + REENTRY_BITS'(1);
                     end
                  end
                  OP_REL_EXCL: begin
                     if ((owner_ff == '0) || (owner_ff != id_ff)) begin
                        status_in = ST_MISUSE;
                     end else begin
                        if (reentry_ff != '0) begin
                           reentry_in = reentry_ff - REENTRY_BITS'(1);
                        end
                        if (reentry_ff <= REENTRY_BITS'(1)) begin
                           owner_in = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_WAIT: begin
            if (eng_stat.done) begin
               state_in = S_FINISH;
               if (op_ff == OP_REL_SHARED) begin
                  if (eng_stat.found) begin
                     count_in  = count_ff - CNT_BITS'(1);
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_MISUSE;  // id not among the readers
                  end
               end else if (!eng_stat.only) begin
                  // foreign readers: deadlock when the requester reads too
                  status_in = eng_stat.found ? ST_DEADLOCK : ST_READERS;
               end else if (reentry_full) begin
                  status_in = ST_MISUSE;
               end else begin
                  // only own reader entries: upgrade, entries stay in place
                  owner_in   = id_ff;
                  reentry_in = reentry_ff + REENTRY_BITS'(1);
                  status_in  = ST_OK;
               end
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_total_in  = count_ff;
               rsp_owner_in  = owner_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   rrwl_scan #(
      .READER_SLOTS (READER_SLOTS),
      .ID_BITS      (ID_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .id    (id_ff),
      .count (count_ff),
      .stat  (eng_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         owner_ff     <= '0;
         reentry_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         owner_ff     <= owner_in;
         reentry_ff   <= reentry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.reader_total = rsp_total_ff;
   assign rsp.owner_now    = rsp_owner_ff;

   // An owner exists exactly while the reentry count is nonzero.
   a_owner_reentry: assert property (@(posedge clock) disable iff (reset)
      (owner_ff != '0) == (reentry_ff != '0))
      else $error("owner and reentry count disagree");

   // Reader count never exceeds the list size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(READER_SLOTS))
      else $error("reader count beyond list size");

   // The list engine only finishes while the sequencer waits for it.
   a_eng_done: assert property (@(posedge clock) disable iff (reset)
      eng_stat.done |-> (state_ff == S_WAIT))
      else $error("list engine done outside wait state");

   // Reader count moves by at most one entry per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CNT_BITS'(1)) ||
          (count_ff == $past(count_ff) - CNT_BITS'(1))))
      else $error("reader count jumped");

endmodule
